/* src/date_difference_days_top_macros.svh */
// assertion macros shared by the date difference block
`ifndef DATE_DIFFERENCE_DAYS_TOP_MACROS_SVH
`define DATE_DIFFERENCE_DAYS_TOP_MACROS_SVH

// same-cycle implication
`define DDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// delayed implication, with the delay given by n
`define DDD_ASSERT_AFTER(label, ante, cons, n, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

/* src/ddd_pkg.sv */
// shared types, constants and month table for the date difference block
package ddd_pkg;

  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned DiffW    = 23;
  localparam int unsigned DayNumW  = 23;
  localparam int unsigned RestW    = 9;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  // floor(x/100) = (x*RECIP)>>21 and floor(x/400) = (x*RECIP)>>23 for x < 2**15
  localparam logic [14:0] RECIP         = 15'd20972;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [3:0]  IDX_MAR   = 4'd2;

  localparam logic signed [DiffW-1:0] DIFF_MAX = {1'b0, {(DiffW-1){1'b1}}};
  localparam logic signed [DiffW-1:0] DIFF_MIN = {1'b1, {(DiffW-1){1'b0}}};

  // one date after the division stage
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [3:0]        month_idx;
    logic [DayW-1:0]   day;
    logic [12:0]       ceil4;
    logic [7:0]        ceil100;
    logic [5:0]        ceil400;
  } ddd_div_t;

  // days in a common year before the first of each month, index 0 is january
  function automatic logic [RestW-1:0] month_start(input logic [3:0] idx);
    logic [RestW-1:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/ddd_year_div.sv */
// first stage: month clamp and leap-year quotients of one date
module ddd_year_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [ddd_pkg::DayW-1:0]   day,
  input  logic [ddd_pkg::MonthW-1:0] month,
  input  logic [ddd_pkg::YearW-1:0]  year,
  output logic                       out_valid,
  output ddd_pkg::ddd_div_t          div
);
  import ddd_pkg::*;

  logic [14:0]  x4;
  logic [14:0]  x100;
  logic [14:0]  x400;
  logic [29:0]  p100;
  logic [29:0]  p400;
  logic [3:0]   month_clamped;
  ddd_div_t     div_next;

  always_comb begin
    x4   = 15'(year) + 15'd3;
    x100 = 15'(year) + 15'd99;
    x400 = 15'(year) + 15'd399;
    p100 = 30'(x100) * 30'(RECIP);
    p400 = 30'(x400) * 30'(RECIP);
    if (month < MONTH_JAN) begin
      month_clamped = MONTH_JAN;
    end else if (month > MONTH_DEC) begin
      month_clamped = MONTH_DEC;
    end else begin
      month_clamped = month;
    end
    div_next.year      = year;
    div_next.month_idx = month_clamped - 4'd1;
    div_next.day       = day;
    div_next.ceil4     = x4[14:2];
    div_next.ceil100   = p100[28:21];
    div_next.ceil400   = p400[28:23];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    div <= div_next;
  end

endmodule

/* src/ddd_day_count.sv */
// second and third stages: absolute day number of one date
module ddd_day_count (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  ddd_pkg::ddd_div_t           div,
  output logic                        out_valid,
  output logic [ddd_pkg::DayNumW-1:0] day_num
);
  import ddd_pkg::*;

  logic [DayNumW-1:0] year_days_next;
  logic [RestW-1:0]   rest_next;
  logic [DayNumW-1:0] year_days;
  logic [RestW-1:0]   rest;
  logic               mid_valid;
  logic [14:0]        back100;
  logic [14:0]        back400;
  logic               leap;

  always_comb begin
    // ceil(y/100)*100 equals y only when y is a multiple of 100
    back100 = 15'(div.ceil100) * 15'd100;
    back400 = 15'(div.ceil400) * 15'd400;
    leap    = (div.year[1:0] == 2'b00) &&
              ((back100 != 15'(div.year)) || (back400 == 15'(div.year)));
    year_days_next = DayNumW'(div.year) * DayNumW'(DAYS_PER_YEAR)
                   + DayNumW'(div.ceil4) - DayNumW'(div.ceil100)
                   + DayNumW'(div.ceil400);
    rest_next = month_start(div.month_idx)
              + RestW'(leap && (div.month_idx >= IDX_MAR))
              + RestW'(div.day);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    year_days <= year_days_next;
    rest      <= rest_next;
    day_num   <= year_days + DayNumW'(rest);
  end

endmodule

/* src/date_difference_days_top.sv */
// top level: signed day count between two gregorian dates
//
// usage:
//   raise start for one cycle with both dates on the first_* and second_*
//   ports; the transaction is taken at that clock edge since busy never
//   rises. a new date pair may be given in every cycle.
//   at the end of the pipeline done is high for exactly one cycle and day_difference
//   holds the days from the first date to the second, saturated to 23 bits.
//   the pipeline registers, in order, the year quotients by reciprocal
//   multiply, the year and month day counts, the day numbers, then the subtract and saturate.
//   throughput is one transaction per cycle, set by the four-stage pipeline.
//   the receiver cannot stall; every result shows for one cycle only.
//   reset clears all valid bits, dropping transactions in flight; no result
//   appears for them.
`include "date_difference_days_top_macros.svh"

module date_difference_days_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ddd_pkg::DayW-1:0]          first_day,
  input  logic [ddd_pkg::MonthW-1:0]        first_month,
  input  logic [ddd_pkg::YearW-1:0]         first_year,
  input  logic [ddd_pkg::DayW-1:0]          second_day,
  input  logic [ddd_pkg::MonthW-1:0]        second_month,
  input  logic [ddd_pkg::YearW-1:0]         second_year,
  output logic                              done,
  output logic signed [ddd_pkg::DiffW-1:0]  day_difference
);
  import ddd_pkg::*;

  localparam int unsigned LATENCY = 4;

  logic                     take;
  logic                     first_div_valid;
  logic                     second_div_valid;
  ddd_div_t                 first_div;
  ddd_div_t                 second_div;
  logic                     first_num_valid;
  logic                     second_num_valid;
  logic [DayNumW-1:0]       first_num;
  logic [DayNumW-1:0]       second_num;
  logic signed [DiffW:0]    diff_wide;
  logic signed [DiffW-1:0]  diff_next;

  assign busy = 1'b0;
  assign take = start && !busy;

  ddd_year_div u_first_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take),
    .day       (first_day),
    .month     (first_month),
    .year      (first_year),
    .out_valid (first_div_valid),
    .div       (first_div)
  );

  ddd_year_div u_second_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take),
    .day       (second_day),
    .month     (second_month),
    .year      (second_year),
    .out_valid (second_div_valid),
    .div       (second_div)
  );

  ddd_day_count u_first_count (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (first_div_valid),
    .div       (first_div),
    .out_valid (first_num_valid),
    .day_num   (first_num)
  );

  ddd_day_count u_second_count (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (second_div_valid),
    .div       (second_div),
    .out_valid (second_num_valid),
    .day_num   (second_num)
  );

  always_comb begin
    diff_wide = $signed({1'b0, second_num}) - $signed({1'b0, first_num});
    // top two bits disagree when the difference leaves the 23-bit range
    if (diff_wide[DiffW] != diff_wide[DiffW-1]) begin
      diff_next = diff_wide[DiffW] ? DIFF_MIN : DIFF_MAX;
    end else begin
      diff_next = diff_wide[DiffW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= first_num_valid && second_num_valid;
    end
  end

  always_ff @(posedge clk) begin
    day_difference <= diff_next;
  end

  `DDD_ASSERT_AFTER(a_take_gives_done, take, done, LATENCY,
    "accepted transaction produced no result")
  `DDD_ASSERT_NOW(a_done_has_source, done, $past(take, LATENCY),
    "result without an accepted transaction")
  `DDD_ASSERT_AFTER(a_same_date_zero,
    take && (first_day == second_day) && (first_month == second_month) &&
    (first_year == second_year),
    day_difference == '0, LATENCY, "equal dates gave a nonzero difference")

endmodule

/* dv/tb.sv */
// testbench for the gregorian day difference block: directed and random date pairs
`timescale 1ns / 100ps

module tb;

  localparam int ClkHalf    = 10;
  localparam int CycleLimit = 200000;

  // days in a common year before the first of each month, january first
  localparam int MonthOffset [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  logic                                   clk = 1'b0;
  logic                                   rst;
  logic                                   start;
  logic                                   busy;
  logic [ddd_pkg::DayW-1:0]               first_day;
  logic [ddd_pkg::MonthW-1:0]             first_month;
  logic [ddd_pkg::YearW-1:0]              first_year;
  logic [ddd_pkg::DayW-1:0]               second_day;
  logic [ddd_pkg::MonthW-1:0]             second_month;
  logic [ddd_pkg::YearW-1:0]              second_year;
  logic                                   done;
  logic signed [ddd_pkg::DiffW-1:0]       day_difference;

  logic signed [ddd_pkg::DiffW-1:0]       pending_diffs [$];
  int                                     error_count  = 0;
  int                                     pairs_sent   = 0;
  int                                     diffs_seen   = 0;
  int                                     sat_count    = 0;
  int                                     cycle_count  = 0;
  int                                     burst_left   = 0;
  bit                                     start_on     = 1'b0;

  date_difference_days_top u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .first_day      (first_day),
    .first_month    (first_month),
    .first_year     (first_year),
    .second_day     (second_day),
    .second_month   (second_month),
    .second_year    (second_year),
    .done           (done),
    .day_difference (day_difference)
  );

  always #(ClkHalf) clk = ~clk;

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // day count from the start of year 0; month is clamped, day taken as it stands
  function automatic int abs_day(input int d, input int m, input int y);
    int mm;
    int n;
    mm = (m < 1) ? 1 : ((m > 12) ? 12 : m);
    n  = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    n += MonthOffset[mm-1] + d;
    if (mm > 2 && leap_year(y)) n++;
    return n;
  endfunction

  function automatic logic signed [ddd_pkg::DiffW-1:0] days_between(
    input int d1, input int m1, input int y1,
    input int d2, input int m2, input int y2
  );
    int diff;
    diff = abs_day(d2, m2, y2) - abs_day(d1, m1, y1);
    if (diff > int'(ddd_pkg::DIFF_MAX)) diff = int'(ddd_pkg::DIFF_MAX);
    if (diff < int'(ddd_pkg::DIFF_MIN)) diff = int'(ddd_pkg::DIFF_MIN);
    return diff[ddd_pkg::DiffW-1:0];
  endfunction

  function automatic int month_len(input int m, input int y);
    case (m)
      2:              return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  task automatic lower_start();
    if (start_on) begin
      start    <= 1'b0;
      start_on  = 1'b0;
    end
  endtask

  // bursts of back-to-back transactions separated by random gaps
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      lower_start();
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_pair(
    input logic [ddd_pkg::DayW-1:0]   d1,
    input logic [ddd_pkg::MonthW-1:0] m1,
    input logic [ddd_pkg::YearW-1:0]  y1,
    input logic [ddd_pkg::DayW-1:0]   d2,
    input logic [ddd_pkg::MonthW-1:0] m2,
    input logic [ddd_pkg::YearW-1:0]  y2
  );
    logic signed [ddd_pkg::DiffW-1:0] exp_diff;
    start        <= 1'b1;
    start_on      = 1'b1;
    first_day    <= d1;
    first_month  <= m1;
    first_year   <= y1;
    second_day   <= d2;
    second_month <= m2;
    second_year  <= y2;
    do @(posedge clk); while (busy);
    exp_diff = days_between(int'(d1), int'(m1), int'(y1), int'(d2), int'(m2), int'(y2));
    if (exp_diff == ddd_pkg::DIFF_MAX || exp_diff == ddd_pkg::DIFF_MIN) sat_count++;
    pending_diffs.push_back(exp_diff);
    pairs_sent++;
    pace();
  endtask

  task automatic wait_drained();
    lower_start();
    while (pending_diffs.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_pair(5'd1,  4'd1,  14'd1,     5'd1,  4'd1,  14'd1);
    send_pair(5'd1,  4'd1,  14'd1,     5'd31, 4'd12, 14'd9999);
    send_pair(5'd31, 4'd12, 14'd9999,  5'd1,  4'd1,  14'd1);
    // full field range saturates both ways
    send_pair(5'd0,  4'd0,  14'd0,     5'd31, 4'd15, 14'd16383);
    send_pair(5'd31, 4'd15, 14'd16383, 5'd0,  4'd0,  14'd0);
    send_pair(5'd1,  4'd1,  14'd0,     5'd1,  4'd3,  14'd0);
    // month zero acts as january, 13 to 15 as december
    send_pair(5'd10, 4'd0,  14'd2024,  5'd10, 4'd1,  14'd2024);
    send_pair(5'd10, 4'd12, 14'd2024,  5'd10, 4'd13, 14'd2024);
    send_pair(5'd10, 4'd14, 14'd2023,  5'd10, 4'd15, 14'd2024);
    // unchecked days: day 0 and overlong months
    send_pair(5'd0,  4'd3,  14'd2023,  5'd28, 4'd2,  14'd2023);
    send_pair(5'd1,  4'd3,  14'd2023,  5'd31, 4'd2,  14'd2023);
    send_pair(5'd31, 4'd4,  14'd2023,  5'd1,  4'd5,  14'd2023);
    // leap rules: by 4, not by 100, by 400
    send_pair(5'd28, 4'd2,  14'd2004,  5'd1,  4'd3,  14'd2004);
    send_pair(5'd28, 4'd2,  14'd1900,  5'd1,  4'd3,  14'd1900);
    send_pair(5'd28, 4'd2,  14'd2000,  5'd1,  4'd3,  14'd2000);
    send_pair(5'd1,  4'd1,  14'd1900,  5'd1,  4'd1,  14'd2100);
    send_pair(5'd31, 4'd12, 14'd1999,  5'd1,  4'd1,  14'd2000);
    send_pair(5'd1,  4'd1,  14'd10000, 5'd1,  4'd1,  14'd9999);
    send_pair(5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383);
    send_pair(5'd1,  4'd1,  14'd5000,  5'd1,  4'd1,  14'd16383);
  endtask

  task automatic test_valid_dates(input int count);
    int y1, m1, d1, y2, m2, d2;
    repeat (count) begin
      y1 = $urandom_range(1, 9999);
      m1 = $urandom_range(1, 12);
      d1 = $urandom_range(1, month_len(m1, y1));
      case ($urandom_range(0, 3))
        0: y2 = $urandom_range(1, 9999);
        1: y2 = y1;
        2: begin
          y2 = y1 + $urandom_range(0, 6) - 3;
          if (y2 < 1) y2 = 1;
          if (y2 > 9999) y2 = 9999;
        end
        default: y2 = y1;
      endcase
      m2 = $urandom_range(1, 12);
      d2 = $urandom_range(1, month_len(m2, y2));
      send_pair(5'(d1), 4'(m1), 14'(y1), 5'(d2), 4'(m2), 14'(y2));
    end
  endtask

  task automatic test_raw_fields(input int count);
    logic [ddd_pkg::YearW-1:0] y1, y2;
    repeat (count) begin
      y1 = 14'($urandom_range(0, 16383));
      y2 = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(0, 16383)) : y1;
      send_pair(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)), y1,
                5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)), y2);
    end
  endtask

  // sender holds off until every outstanding difference has come back
  task automatic test_drain_pause();
    repeat (5) begin
      test_valid_dates($urandom_range(5, 15));
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_diffs.size() == 0) begin
        $error("day_difference: no result expected, got %0d", day_difference);
        error_count++;
      end else begin
        if (day_difference !== pending_diffs[0]) begin
          $error("day_difference: expected %0d, actual %0d", pending_diffs[0], day_difference);
          error_count++;
        end
        void'(pending_diffs.pop_front());
        diffs_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[date_difference_days_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    first_day    = '0;
    first_month  = '0;
    first_year   = '0;
    second_day   = '0;
    second_month = '0;
    second_year  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_valid_dates(800);
    test_drain_pause();
    test_raw_fields(500);
    test_valid_dates(400);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d date pairs (directed, well-formed and raw field values), %0d checked",
             pairs_sent, diffs_seen);
    $display("%0d transactions hit the 23-bit saturation limits", sat_count);
    if (error_count == 0) begin
      $display("[date_difference_days_top] OK");
    end else begin
      $display("[date_difference_days_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/ddd_pkg.sv
src/ddd_year_div.sv
src/ddd_day_count.sv
src/date_difference_days_top.sv
dv/tb.sv
